>>> rtl/assert_macros.svh
// Assertion macros shared by the address region table RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ART_ASSERT_IMP(label, clk_s, rst_ns, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ART_ASSERT_NEXT(label, clk_s, rst_ns, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/art_pkg.sv
// Package for the address region table: widths, codes and defaults.
// No dependencies.
`default_nettype none
package art_pkg;
  localparam int unsigned TableEntries = 16;
  localparam int unsigned PageShift    = 12;
  localparam int unsigned AddrBits     = 39;
  localparam int unsigned OffBits      = 40;
  localparam int unsigned TopBits      = 40;
  localparam logic [TopBits-1:0] TopReset = 40'd274877906944;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_FREE   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO_LEN = 3'd1,
    ST_OVERLAP  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;
endpackage
`default_nettype wire

>>> rtl/art_if.sv
// Valid/ready channel interfaces for the address region table.
// Depends on art_pkg for field widths.
`default_nettype none
interface art_req_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     cmd;
  logic [art_pkg::AddrBits-1:0]   address;
  logic [art_pkg::AddrBits:0]     span;
  logic [art_pkg::OffBits-1:0]    file_offset;
  logic [2:0]                     protection;
  logic [7:0]                     map_flags;
  logic [9:0]                     file_tag;
  logic [3:0]                     slot_index;
  modport source (output valid, cmd, address, span, file_offset, protection, map_flags,
                  file_tag, slot_index, input ready);
  modport sink (input valid, cmd, address, span, file_offset, protection, map_flags,
                file_tag, slot_index, output ready);
endinterface

interface art_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     status;
  logic [3:0]                     hit_slot;
  logic [art_pkg::AddrBits-1:0]   hit_start;
  logic [art_pkg::AddrBits:0]     hit_length;
  logic [art_pkg::OffBits-1:0]    hit_offset;
  logic [2:0]                     hit_protection;
  logic [7:0]                     hit_flags;
  logic [9:0]                     hit_file;
  logic [4:0]                     removed_count;
  logic [4:0]                     live_entries;
  logic [art_pkg::AddrBits-1:0]   free_start;
  modport source (output valid, status, hit_slot, hit_start, hit_length, hit_offset,
                  hit_protection, hit_flags, hit_file, removed_count, live_entries,
                  free_start, input ready);
  modport sink (input valid, status, hit_slot, hit_start, hit_length, hit_offset,
                hit_protection, hit_flags, hit_file, removed_count, live_entries,
                free_start, output ready);
endinterface

interface art_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [art_pkg::TopBits-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> rtl/address_region_table_core.sv
// Address region table top: sequencer, entry store and shared compare unit.
// Depends on art_pkg, art_if.sv and assert_macros.svh.
// Lookup and remove make one pass over the table (N = TABLE_ENTRIES, one entry a cycle); an insert
// that clears the overlap pass makes a second pass for the lowest free slot; free, clear and zero length
// make no pass. Find free makes a hint pass (nonzero address only) and up to N+1 downward passes.
// in_ready stays low until the result is taken: no new command is accepted before then.
// Reset (rst_n low, synchronous) clears all valid bits, file tags and the count.
`default_nettype none
`include "assert_macros.svh"
module address_region_table_core #(
  parameter int unsigned TABLE_ENTRIES = art_pkg::TableEntries,
  parameter int unsigned PAGE_SHIFT    = art_pkg::PageShift,
  parameter int unsigned ADDR_BITS     = art_pkg::AddrBits
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  art_req_if.sink    in_ch,
  art_rsp_if.source  out_ch,
  art_cfg_if.sink    cfg_ch
);
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned LW = ADDR_BITS + 1;
  localparam int unsigned LX = LW + 1;  // one spare bit for sums

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_SCAN = 5'b00100,
    S_DEC  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PH_MAIN = 2'd0,   // overlap / lookup / remove pass
    PH_SLOT = 2'd1,   // insert: lowest free slot
    PH_HINT = 2'd2,   // find free: hint overlap pass
    PH_DOWN = 2'd3    // find free: downward candidate pass
  } phase_t;

  state_t state_r;
  phase_t phase_r;

  // entry store
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [ADDR_BITS-1:0]     e_start_r [TABLE_ENTRIES];
  logic [LW-1:0]            e_len_r   [TABLE_ENTRIES];
  logic [art_pkg::OffBits-1:0] e_off_r [TABLE_ENTRIES];
  logic [2:0]               e_prot_r  [TABLE_ENTRIES];
  logic [7:0]               e_flag_r  [TABLE_ENTRIES];
  logic [9:0]               e_file_r  [TABLE_ENTRIES];
  logic [CW-1:0]            count_r;
  logic [art_pkg::TopBits-1:0] top_cfg_r;

  // command registers
  logic [2:0]               cmd_r;
  logic [ADDR_BITS-1:0]     addr_r;
  logic [LW-1:0]            span_r;
  logic [LW-1:0]            len_r;
  logic [art_pkg::OffBits-1:0] foff_r;
  logic [2:0]               prot_r;
  logic [7:0]               mflag_r;
  logic [9:0]               ftag_r;
  logic [3:0]               sidx_r;
  logic [LX-1:0]            top_r;
  logic [LX-1:0]            cand_r;    // candidate start for overlap scans
  logic [IW:0]              idx_r;
  logic                     found_r;
  logic [IW-1:0]            fidx_r;
  logic [CW-1:0]            rem_r;
  logic [4:0]               iter_r;

  // result registers
  logic                     ovalid_r;
  logic [2:0]               st_r;
  logic [3:0]               hslot_r;
  logic [ADDR_BITS-1:0]     hstart_r;
  logic [LW-1:0]            hlen_r;
  logic [art_pkg::OffBits-1:0] hoff_r;
  logic [2:0]               hprot_r;
  logic [7:0]               hflag_r;
  logic [9:0]               hfile_r;
  logic [ADDR_BITS-1:0]     fstart_r;

  localparam logic [LX-1:0] PageLow = LX'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [LX-1:0] PageSz  = LX'(64'd1 << PAGE_SHIFT);
  localparam logic [LX-1:0] LenLim  = LX'(((65'd1 << LW) - 65'd1) & ~65'(PageLow));
  localparam logic [LX-1:0] AddrLim = LX'(65'd1 << ADDR_BITS);

  wire logic in_fire  = in_ch.valid & in_ch.ready;
  wire logic out_fire = out_ch.valid & out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // shared compare unit: one entry against the current candidate/command
  wire logic [IW-1:0] ci = idx_r[IW-1:0];
  logic [LX-1:0] ent_s, ent_e, cand_e, rem_e, addr_x;
  logic hit_ovl, hit_look, hit_rem;
  always_comb begin
    ent_s  = LX'(e_start_r[ci]);
    ent_e  = LX'(e_start_r[ci]) + LX'(e_len_r[ci]);
    cand_e = cand_r + LX'(len_r);
    addr_x = LX'(addr_r);
    rem_e  = addr_x + LX'(span_r);
    hit_ovl  = valid_r[ci] && !(cand_r >= ent_e || cand_e <= ent_s);
    hit_look = valid_r[ci] && addr_x >= ent_s && addr_x < ent_e;
    hit_rem  = valid_r[ci] && addr_x <= ent_s && ent_e <= rem_e;
  end

  wire logic scan_last = (idx_r == (IW+1)'(TABLE_ENTRIES - 1));

  logic [LX-1:0] len_up, top_c;
  always_comb begin
    len_up = (LX'(in_ch.span) + PageLow) & ~PageLow;
    if (len_up > LenLim) len_up = LenLim;
    top_c = LX'(top_cfg_r);
    if (top_c > AddrLim) top_c = AddrLim;
    top_c = top_c & ~PageLow;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= PH_MAIN;
      valid_r   <= '0;
      count_r   <= '0;
      ovalid_r  <= 1'b0;
      top_cfg_r <= art_pkg::TopReset;
      for (int i = 0; i < TABLE_ENTRIES; i++) e_file_r[i] <= '0;
    end else begin
      if (cfg_ch.valid) top_cfg_r <= cfg_ch.data;
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          cmd_r   <= in_ch.cmd;
          addr_r  <= in_ch.address;
          span_r  <= in_ch.span;
          len_r   <= LW'(len_up);
          foff_r  <= in_ch.file_offset;
          prot_r  <= in_ch.protection;
          mflag_r <= in_ch.map_flags;
          ftag_r  <= in_ch.file_tag;
          sidx_r  <= in_ch.slot_index;
          top_r   <= top_c;
          cand_r  <= LX'(in_ch.address) & ~PageLow;
          phase_r <= (in_ch.cmd == art_pkg::CMD_FIND) ? PH_HINT : PH_MAIN;
          st_r <= art_pkg::ST_OK; hslot_r <= '0; hstart_r <= '0; hlen_r <= '0;
          hoff_r <= '0; hprot_r <= '0; hflag_r <= '0; hfile_r <= '0; fstart_r <= '0;
          iter_r <= '0;
          state_r <= S_PREP;
        end
        S_PREP: begin
          idx_r <= '0; found_r <= 1'b0; fidx_r <= '0; rem_r <= '0;
          priority if (cmd_r == art_pkg::CMD_INSERT || cmd_r == art_pkg::CMD_FIND) begin
            if (span_r == '0) begin
              st_r <= art_pkg::ST_ZERO_LEN; state_r <= S_OUT; ovalid_r <= 1'b1;
            end else if (cmd_r == art_pkg::CMD_FIND && addr_r == '0) begin
              // no hint: go straight to the downward pass
              phase_r <= PH_DOWN;
              cand_r  <= top_r - LX'(len_r);
              if (LX'(len_r) > top_r || (top_r - LX'(len_r)) < PageSz) begin
                st_r <= art_pkg::ST_NOTFOUND; state_r <= S_OUT; ovalid_r <= 1'b1;
              end else state_r <= S_SCAN;
            end else state_r <= S_SCAN;
          end else if (cmd_r == art_pkg::CMD_FREE) begin
            if (32'(sidx_r) < TABLE_ENTRIES && valid_r[IW'(sidx_r)]) begin
              valid_r[IW'(sidx_r)]  <= 1'b0;
              e_file_r[IW'(sidx_r)] <= '0;
              count_r <= count_r - 1'b1;
            end else st_r <= art_pkg::ST_NOTFOUND;
            state_r <= S_OUT; ovalid_r <= 1'b1;
          end else if (cmd_r == art_pkg::CMD_CLEAR) begin
            valid_r <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) e_file_r[i] <= '0;
            count_r <= '0;
            state_r <= S_OUT; ovalid_r <= 1'b1;
          end else if (cmd_r == art_pkg::CMD_LOOKUP || cmd_r == art_pkg::CMD_REMOVE) begin
            state_r <= S_SCAN;
          end else begin
            st_r <= art_pkg::ST_NOTFOUND; state_r <= S_OUT; ovalid_r <= 1'b1;
          end
        end
        S_SCAN: begin
          idx_r <= idx_r + 1'b1;
          if (cmd_r == art_pkg::CMD_REMOVE) begin
            if (hit_rem) begin
              valid_r[ci] <= 1'b0; e_file_r[ci] <= '0; rem_r <= rem_r + 1'b1;
            end
          end else if (!found_r) begin
            // keep the lowest matching slot
            unique case (phase_r)
              PH_SLOT: if (!valid_r[ci]) begin found_r <= 1'b1; fidx_r <= ci; end
              PH_MAIN: if (cmd_r == art_pkg::CMD_LOOKUP ? hit_look : hit_ovl) begin
                found_r <= 1'b1; fidx_r <= ci;
              end
              default: if (hit_ovl) begin found_r <= 1'b1; fidx_r <= ci; end
            endcase
          end
          if (scan_last) state_r <= S_DEC;
        end
        S_DEC: begin
          idx_r <= '0; found_r <= 1'b0;
          unique case (cmd_r)
            art_pkg::CMD_REMOVE: begin
              count_r <= count_r - rem_r;
              state_r <= S_OUT; ovalid_r <= 1'b1;
            end
            art_pkg::CMD_LOOKUP: begin
              if (found_r) begin
                hslot_r  <= 4'(fidx_r);
                hstart_r <= e_start_r[fidx_r];
                hlen_r   <= e_len_r[fidx_r];
                hoff_r   <= e_off_r[fidx_r];
                hprot_r  <= e_prot_r[fidx_r];
                hflag_r  <= e_flag_r[fidx_r];
                hfile_r  <= e_file_r[fidx_r];
              end else st_r <= art_pkg::ST_NOTFOUND;
              state_r <= S_OUT; ovalid_r <= 1'b1;
            end
            art_pkg::CMD_INSERT: begin
              if (phase_r == PH_MAIN && !found_r) begin
                phase_r <= PH_SLOT; state_r <= S_SCAN;
              end else begin
                if (phase_r == PH_MAIN) st_r <= art_pkg::ST_OVERLAP;
                else if (!found_r) st_r <= art_pkg::ST_FULL;
                else begin
                  valid_r[fidx_r]   <= 1'b1;
                  e_start_r[fidx_r] <= ADDR_BITS'(cand_r);
                  e_len_r[fidx_r]   <= len_r;
                  e_off_r[fidx_r]   <= foff_r;
                  e_prot_r[fidx_r]  <= prot_r;
                  e_flag_r[fidx_r]  <= mflag_r;
                  e_file_r[fidx_r]  <= ftag_r;
                  count_r <= count_r + 1'b1;
                  hslot_r <= 4'(fidx_r);
                end
                state_r <= S_OUT; ovalid_r <= 1'b1;
              end
            end
            art_pkg::CMD_FIND: begin
              if (phase_r == PH_HINT) begin
                if (!found_r && (cand_r + LX'(len_r)) < top_r) begin
                  fstart_r <= ADDR_BITS'(cand_r);
                  state_r <= S_OUT; ovalid_r <= 1'b1;
                end else if (LX'(len_r) > top_r || (top_r - LX'(len_r)) < PageSz) begin
                  st_r <= art_pkg::ST_NOTFOUND; state_r <= S_OUT; ovalid_r <= 1'b1;
                end else begin
                  phase_r <= PH_DOWN; cand_r <= top_r - LX'(len_r);
                  state_r <= S_SCAN;
                end
              end else if (!found_r) begin
                fstart_r <= ADDR_BITS'(cand_r);
                state_r <= S_OUT; ovalid_r <= 1'b1;
              end else if (LX'(len_r) > LX'(e_start_r[fidx_r]) ||
                           iter_r == 5'(TABLE_ENTRIES) ||
                           (LX'(e_start_r[fidx_r]) - LX'(len_r)) < PageSz) begin
                st_r <= art_pkg::ST_NOTFOUND; state_r <= S_OUT; ovalid_r <= 1'b1;
              end else begin
                cand_r <= LX'(e_start_r[fidx_r]) - LX'(len_r);
                iter_r <= iter_r + 1'b1;
                state_r <= S_SCAN;
              end
            end
            default: begin
              st_r <= art_pkg::ST_NOTFOUND; state_r <= S_OUT; ovalid_r <= 1'b1;
            end
          endcase
        end
        S_OUT: if (out_fire) begin
          ovalid_r <= 1'b0; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.status         = st_r;
  assign out_ch.hit_slot       = hslot_r;
  assign out_ch.hit_start      = hstart_r;
  assign out_ch.hit_length     = hlen_r;
  assign out_ch.hit_offset     = hoff_r;
  assign out_ch.hit_protection = hprot_r;
  assign out_ch.hit_flags      = hflag_r;
  assign out_ch.hit_file       = hfile_r;
  assign out_ch.removed_count  = (cmd_r == art_pkg::CMD_REMOVE) ? 5'(rem_r) : 5'd0;
  assign out_ch.live_entries   = 5'(count_r);
  assign out_ch.free_start     = fstart_r;

  `ART_ASSERT_IMP(a_busy_no_ready, clk, rst_n, state_r != S_IDLE, !in_ch.ready)
  `ART_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, 32'(count_r) <= TABLE_ENTRIES)
  `ART_ASSERT_IMP(a_valid_in_out, clk, rst_n, ovalid_r, state_r == S_OUT)
  `ART_ASSERT_NEXT(a_out_done, clk, rst_n, out_fire, !ovalid_r)
endmodule
`default_nettype wire

>>> bench/region_table_checker.sv
`timescale 1ns / 100ps
// Checker for the address region table: watches the request, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on art_pkg and the channel interfaces in art_if.sv.
module region_table_checker (
  input  logic clk,
  input  logic rst_n,
  art_req_if   req,
  art_rsp_if   rsp,
  art_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);
  import art_pkg::*;

  localparam int unsigned N = TableEntries;
  localparam bit [63:0] PAGE_BYTES = 64'd1 << PageShift;
  localparam bit [63:0] PAGE_LOW   = PAGE_BYTES - 64'd1;
  localparam bit [63:0] ADDR_MASK  = (64'd1 << AddrBits) - 64'd1;
  localparam bit [63:0] LEN_MASK   = (64'd1 << (AddrBits + 1)) - 64'd1;

  typedef struct packed {
    logic [2:0]          status;
    logic [3:0]          hit_slot;
    logic [AddrBits-1:0] hit_start;
    logic [AddrBits:0]   hit_length;
    logic [OffBits-1:0]  hit_offset;
    logic [2:0]          hit_protection;
    logic [7:0]          hit_flags;
    logic [9:0]          hit_file;
    logic [4:0]          removed_count;
    logic [4:0]          live_entries;
    logic [AddrBits-1:0] free_start;
  } region_result_t;

  bit                  slot_used  [N];
  bit [63:0]           slot_start [N];
  bit [63:0]           slot_len   [N];
  bit [OffBits-1:0]    slot_off   [N];
  bit [2:0]            slot_prot  [N];
  bit [7:0]            slot_flags [N];
  bit [9:0]            slot_file  [N];
  int unsigned         live_count;
  bit [63:0]           search_top;
  region_result_t      expected_q[$];

  function automatic bit [63:0] round_to_pages(bit [63:0] l);
    bit [63:0] r, lim;
    r   = (l + PAGE_LOW) & ~PAGE_LOW;
    lim = LEN_MASK & ~PAGE_LOW;
    return (r > lim) ? lim : r;
  endfunction

  function automatic int lowest_overlap(bit [63:0] a, bit [63:0] len);
    for (int i = 0; i < N; i++) begin
      if (slot_used[i] && !(a >= slot_start[i] + slot_len[i] || a + len <= slot_start[i]))
        return i;
    end
    return -1;
  endfunction

  function automatic void release_slot(int i);
    slot_used[i] = 1'b0;
    slot_file[i] = '0;
    live_count--;
  endfunction

  function automatic region_result_t apply_command();
    region_result_t r;
    bit [63:0] addr, span, a, len, t;
    int slot, k, removed;
    bit done, stop;
    r = '0;
    addr = 64'(req.address) & ADDR_MASK;
    span = 64'(req.span) & LEN_MASK;
    case (cmd_t'(req.cmd))
      CMD_INSERT: begin
        if (span == 0) begin
          r.status = ST_ZERO_LEN;
        end else begin
          a = addr & ~PAGE_LOW;
          len = round_to_pages(span);
          slot = -1;
          for (int i = N - 1; i >= 0; i--) if (!slot_used[i]) slot = i;
          if (lowest_overlap(a, len) >= 0) begin
            r.status = ST_OVERLAP;
          end else if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_used[slot]  = 1'b1;
            slot_start[slot] = a;
            slot_len[slot]   = len;
            slot_off[slot]   = req.file_offset;
            slot_prot[slot]  = req.protection;
            slot_flags[slot] = req.map_flags;
            slot_file[slot]  = req.file_tag;
            live_count++;
            r.hit_slot = slot[3:0];
          end
        end
      end
      CMD_LOOKUP: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < N; i++) begin
          if (r.status == ST_NOTFOUND && slot_used[i] && addr >= slot_start[i] &&
              addr < slot_start[i] + slot_len[i]) begin
            r.status         = ST_OK;
            r.hit_slot       = i[3:0];
            r.hit_start      = slot_start[i][AddrBits-1:0];
            r.hit_length     = slot_len[i][AddrBits:0];
            r.hit_offset     = slot_off[i];
            r.hit_protection = slot_prot[i];
            r.hit_flags      = slot_flags[i];
            r.hit_file       = slot_file[i];
          end
        end
      end
      CMD_REMOVE: begin
        removed = 0;
        for (int i = 0; i < N; i++) begin
          if (slot_used[i] && addr <= slot_start[i] &&
              slot_start[i] + slot_len[i] <= addr + span) begin
            release_slot(i);
            removed++;
          end
        end
        r.removed_count = removed[4:0];
      end
      CMD_FIND: begin
        if (span == 0) begin
          r.status = ST_ZERO_LEN;
        end else begin
          len = round_to_pages(span);
          t = search_top;
          if (t > ADDR_MASK + 1) t = ADDR_MASK + 1;
          t &= ~PAGE_LOW;
          done = 1'b0;
          if (addr != 0) begin
            a = addr & ~PAGE_LOW;
            if (lowest_overlap(a, len) < 0 && a + len < t) begin
              r.free_start = a[AddrBits-1:0];
              done = 1'b1;
            end
          end
          if (!done && len <= t) begin
            a = t - len;
            stop = 1'b0;
            for (int it = 0; it <= N && a >= PAGE_BYTES && !stop; it++) begin
              k = lowest_overlap(a, len);
              if (k < 0) begin
                r.free_start = a[AddrBits-1:0];
                done = 1'b1;
                stop = 1'b1;
              end else if (len > slot_start[k]) begin
                stop = 1'b1;
              end else begin
                a = slot_start[k] - len;
              end
            end
          end
          if (!done) r.status = ST_NOTFOUND;
        end
      end
      CMD_FREE: begin
        if (req.slot_index < N && slot_used[req.slot_index])
          release_slot(int'(req.slot_index));
        else r.status = ST_NOTFOUND;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < N; i++) begin
          slot_used[i] = 1'b0;
          slot_file[i] = '0;
        end
        live_count = 0;
      end
      default: r.status = ST_NOTFOUND;
    endcase
    r.live_entries = live_count[4:0];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    region_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        slot_used[i] = 1'b0;
        slot_file[i] = '0;
      end
      live_count = 0;
      search_top = 64'(TopReset);
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) search_top = 64'(cfg.data) & LEN_MASK;
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("status", 64'(want.status), 64'(rsp.status));
          compare_field("hit_slot", 64'(want.hit_slot), 64'(rsp.hit_slot));
          compare_field("hit_start", 64'(want.hit_start), 64'(rsp.hit_start));
          compare_field("hit_length", 64'(want.hit_length), 64'(rsp.hit_length));
          compare_field("hit_offset", 64'(want.hit_offset), 64'(rsp.hit_offset));
          compare_field("hit_protection", 64'(want.hit_protection),
                        64'(rsp.hit_protection));
          compare_field("hit_flags", 64'(want.hit_flags), 64'(rsp.hit_flags));
          compare_field("hit_file", 64'(want.hit_file), 64'(rsp.hit_file));
          compare_field("removed_count", 64'(want.removed_count), 64'(rsp.removed_count));
          compare_field("live_entries", 64'(want.live_entries), 64'(rsp.live_entries));
          compare_field("free_start", 64'(want.free_start), 64'(rsp.free_start));
        end
      end
      if (req.valid && req.ready) expected_q.push_back(apply_command());
    end
    pending = expected_q.size();
  end
endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Top of the address region table bench: clock, reset, stimulus and verdict.
// Depends on art_pkg, art_if.sv, the core and region_table_checker.
module testbench;
  import art_pkg::*;

  localparam bit [63:0] PAGE_BYTES = 64'd1 << PageShift;
  localparam bit [63:0] ADDR_SPAN  = 64'd1 << AddrBits;
  localparam int        STALL_LIMIT = 6000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending;
  bit   quiet = 1'b0;
  bit   hold_results = 1'b0;
  bit [63:0] cur_top = 64'(TopReset);

  art_req_if req ();
  art_rsp_if rsp ();
  art_cfg_if cfg ();

  address_region_table_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(req), .out_ch(rsp), .cfg_ch(cfg)
  );

  region_table_checker chk (
    .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog: count cycles in which no transaction moves
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready) ||
          !rst_n)
        idle = 0;
      else
        idle++;
      if (idle >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        rsp.ready <= 1'b0;
        repeat (80) @(negedge clk);
        hold_results = 1'b0;
      end else if (!quiet && rst_n && $urandom_range(0, 9) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic send_command(cmd_t c, bit [63:0] addr, bit [63:0] span,
                              bit [39:0] off, bit [2:0] prot, bit [7:0] flags,
                              bit [9:0] tag, bit [3:0] slot);
    if (!quiet && !hold_results && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req.cmd         <= c;
    req.address     <= addr[AddrBits-1:0];
    req.span        <= span[AddrBits:0];
    req.file_offset <= off;
    req.protection  <= prot;
    req.map_flags   <= flags;
    req.file_tag    <= tag;
    req.slot_index  <= slot;
    req.valid       <= 1'b1;
    forever begin
      #1;
      if (req.ready) break;
      @(negedge clk);
    end
    @(negedge clk);
  endtask

  task automatic write_top(bit [63:0] value);
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg.data  <= value[TopBits-1:0];
    cfg.valid <= 1'b1;
    forever begin
      #1;
      if (cfg.ready) break;
      @(negedge clk);
    end
    @(negedge clk);
    cfg.valid <= 1'b0;
    cur_top = value;
  endtask

  function automatic bit [63:0] wide_random(int bits);
    return {$urandom, $urandom} & ((64'd1 << bits) - 64'd1);
  endfunction

  // addresses cluster near the bottom and just under the search top so regions collide
  function automatic bit [63:0] pick_address();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 64'($urandom_range(0, 40)) * PAGE_BYTES + $urandom_range(0, 4095);
    if (sel < 8 && cur_top > 48 * PAGE_BYTES)
      return (cur_top - 64'($urandom_range(1, 48)) * PAGE_BYTES) & (ADDR_SPAN - 1);
    return wide_random(AddrBits);
  endfunction

  function automatic bit [63:0] pick_span();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return 64'($urandom_range(1, 6)) * PAGE_BYTES - $urandom_range(0, 3);
    if (sel < 15) return $urandom_range(1, 65535);
    if (sel < 18) return wide_random(AddrBits);
    if (sel < 19) return 0;
    return ADDR_SPAN;
  endfunction

  task automatic random_command();
    int w;
    cmd_t c;
    w = $urandom_range(0, 99);
    if      (w < 35) c = CMD_INSERT;
    else if (w < 60) c = CMD_LOOKUP;
    else if (w < 70) c = CMD_REMOVE;
    else if (w < 85) c = CMD_FIND;
    else if (w < 96) c = CMD_FREE;
    else             c = CMD_CLEAR;
    send_command(c, ($urandom_range(0, 7) == 0) ? 64'd0 : pick_address(), pick_span(),
                 40'(wide_random(40)), 3'($urandom), 8'($urandom), 10'($urandom),
                 4'($urandom));
  endtask

  initial begin
    bit [63:0] tops[6];
    req.valid = 1'b0; req.cmd = '0; req.address = '0; req.span = '0;
    req.file_offset = '0; req.protection = '0; req.map_flags = '0;
    req.file_tag = '0; req.slot_index = '0;
    cfg.valid = 1'b0; cfg.data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: edge values, each command and the awkward cases
    send_command(CMD_INSERT, 64'h1000, 0, 0, 0, 0, 0, 0);
    send_command(CMD_FIND, 0, 0, 0, 0, 0, 0, 0);
    send_command(CMD_INSERT, ADDR_SPAN - 1, ADDR_SPAN, '1, 3'h7, 8'hff, 10'h3ff, 0);
    send_command(CMD_LOOKUP, ADDR_SPAN - 1, 0, 0, 0, 0, 0, 0);
    send_command(CMD_FIND, 64'h5000, ADDR_SPAN, 0, 0, 0, 0, 0);
    send_command(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_command(CMD_INSERT, 64'h2fff, 64'h1001, 40'h5555555555, 3'h5, 8'h5a, 10'h155, 0);
    send_command(CMD_INSERT, 64'h3000, 64'h1000, 0, 0, 0, 0, 0);
    send_command(CMD_LOOKUP, 64'h4fff, 0, 0, 0, 0, 0, 0);
    send_command(CMD_LOOKUP, 64'h1fff, 0, 0, 0, 0, 0, 0);
    send_command(CMD_FIND, 64'h2000, 64'h1000, 0, 0, 0, 0, 0);
    send_command(CMD_FIND, 64'h40000, 64'h1000, 0, 0, 0, 0, 0);
    send_command(CMD_FIND, 0, 64'(TopReset), 0, 0, 0, 0, 0);
    send_command(CMD_FREE, 0, 0, 0, 0, 0, 0, 4'hf);
    send_command(CMD_REMOVE, 64'h2000, 64'h2000, 0, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++)
      send_command(CMD_INSERT, 64'(i) * 64'h10000, 64'h1000, 40'hAAAAAAAAAA, 3'h2, 8'ha5,
                   10'h2aa, 0);
    send_command(CMD_FREE, 0, 0, 0, 0, 0, 0, 4'h3);
    send_command(CMD_REMOVE, 0, ADDR_SPAN, 0, 0, 0, 0, 0);

    tops[0] = 64'(TopReset);
    tops[1] = 64'h1000;
    tops[2] = ADDR_SPAN;
    tops[3] = 64'd64 * PAGE_BYTES + 64'd123;
    tops[4] = 64'($urandom_range(2, 400)) * PAGE_BYTES;
    tops[5] = wide_random(AddrBits) | PAGE_BYTES;
    for (int p = 0; p < 6; p++) begin
      write_top(tops[p]);
      for (int n = 0; n < 70; n++) begin
        if (p == 2 && n == 20) hold_results = 1'b1;
        if (p == 3 && n == 35) begin
          // drop valid so the last transaction is not offered again while draining
          req.valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
        if (p == 5 && n == 40) quiet = 1'b1;
        random_command();
      end
    end
    req.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
